>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/sse_pkg.sv
// Shared constants and types of the step sequencer engine.
`timescale 1ns / 1ps
package sse_pkg;
	localparam int ROWS    = 8;
	localparam int STEPS   = 8;
	localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int STEP_W  = $clog2(STEPS);
	localparam int CELLS   = ROWS * STEPS;
	localparam int CELL_W  = $clog2(CELLS);
	localparam int NOTES   = 128;
	localparam int NOTE_W  = 7;
	localparam int SWEEP_N = (CELLS > NOTES) ? CELLS : NOTES;
	localparam int SWEEP_W = $clog2(SWEEP_N);
	localparam int PANIC_N = 32;
	localparam int PAN_W   = 5;

	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_GRID   = 2'd1;
	localparam logic [1:0] REQ_ASSIGN = 2'd2;
	localparam logic [1:0] REQ_PANIC  = 2'd3;

	localparam logic CFG_CHANNEL = 1'b0;
	localparam logic CFG_DRUM    = 1'b1;

	localparam logic [7:0] STAT_NOTE_ON  = 8'h90;
	localparam logic [7:0] STAT_NOTE_OFF = 8'h80;
	localparam logic [7:0] STAT_CTRL     = 8'hB0;
	localparam logic [6:0] CC_SUSTAIN    = 7'h40;
	localparam logic [6:0] CC_ALL_OFF    = 7'h7B;
	localparam logic [7:0] CNT_MAX       = 8'd255;
	localparam logic [7:0] ROW_DISABLED  = 8'hFF;

	typedef struct packed {
		logic [15:0] tm;
		logic [7:0]  status;
		logic [6:0]  d1;
		logic [6:0]  d2;
	} msg_t;
endpackage

>>> rtl/core/sse_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module sse_ram #(
	parameter int W = 8,
	parameter int D = 128
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/midi_step_sequencer_engine.sv
// Top level of the MIDI step sequencer engine: request sequencer and state memories.
`timescale 1ns / 1ps
// Usage:
// A request is taken at a rising edge with start high and busy low; req_type picks
// step tick, grid cell write, row note assign or panic. Each MIDI message comes out
// on event_time/status_byte/data_one/data_two for one cycle with event_strobe high;
// last_of_run marks the final beat of a request. The receiver cannot stall.
// Config is to be written by the user through cfg_we/cfg_index/cfg_data while idle; the
// block itself does not enforce this. A grid write goes to the grid RAM as it is taken
// and busy stays low. A step tick walks the rows one at a time through the count and
// grid RAMs: S_ROW for a disabled row; S_ROW, S_EVAL and on a retrigger S_RETRIG for an
// enabled one; S_SCAN_RD and S_SCAN_CK per step scanned on the step-zero full-row check;
// then S_FINISH. A note assign passes S_ASG, S_ASG_EV if the old note was enabled and
// differs, then S_FINISH. A panic sends 32 beats, then sweeps the count RAM. Each beat
// is held until the next one is made or the request finishes. Reset: a clearing pass
// zeroes the count and grid RAMs; busy is high throughout, config writes are taken as ever.
module midi_step_sequencer_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] time_offset,
	input  logic [2:0]  row_index,
	input  logic [2:0]  column_index,
	input  logic [6:0]  cell_velocity,
	input  logic [6:0]  row_note,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data,
	output logic        event_strobe,
	output logic [15:0] event_time,
	output logic [7:0]  status_byte,
	output logic [6:0]  data_one,
	output logic [6:0]  data_two,
	output logic        last_of_run
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_ROW, S_EVAL, S_RETRIG, S_SCAN_RD, S_SCAN_CK,
		S_ASG, S_ASG_EV, S_PANIC, S_FINISH
	} state_t;

	state_t                       state_q;
	logic [sse_pkg::SWEEP_W-1:0]  sweep_q;
	logic                         clr_grid_q;
	logic                         clr_after_q;
	logic [sse_pkg::STEP_W-1:0]   step_q;
	logic [sse_pkg::ROW_W-1:0]    row_q;
	logic [sse_pkg::STEP_W-1:0]   scan_q;
	logic [15:0]                  t_q;
	logic [7:0]                   cnt_q;
	logic [6:0]                   vel_q;
	logic [6:0]                   note_q;
	logic [sse_pkg::ROW_W-1:0]    asg_row_q;
	logic [6:0]                   asg_note_q;
	logic [sse_pkg::PAN_W-1:0]    pan_q;
	logic [3:0]                   chan_q;
	logic                         drum_q;
	logic [7:0]                   map_q [sse_pkg::ROWS];
	sse_pkg::msg_t                pend_q;
	logic                         pend_vld_q;

	logic                         accept;
	logic [7:0]                   cur_note;
	logic [7:0]                   old_note;
	logic                         in_use;
	logic [15:0]                  t_off;
	logic [15:0]                  t_on;
	logic                         emit;
	sse_pkg::msg_t                emit_msg;

	logic                         g_we;
	logic [sse_pkg::CELL_W-1:0]   g_waddr;
	logic [6:0]                   g_wdata;
	logic [sse_pkg::CELL_W-1:0]   g_raddr;
	logic [6:0]                   g_rdata;
	logic                         c_we;
	logic [sse_pkg::NOTE_W-1:0]   c_waddr;
	logic [7:0]                   c_wdata;
	logic [sse_pkg::NOTE_W-1:0]   c_raddr;
	logic [7:0]                   c_rdata;

	logic                         set_c;
	logic                         act_c;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && (state_q == S_IDLE);
	assign cur_note = map_q[row_q];
	assign old_note = map_q[asg_row_q];
	assign t_off    = (t_q == 16'd0) ? 16'd0 : t_q - 16'd1;
	assign t_on     = (t_q == 16'd0) ? 16'd1 : t_q;
	assign set_c    = (g_rdata != 7'd0);
	assign act_c    = (c_rdata != 8'd0);

	always_comb begin
		in_use = 1'b0;
		for (int r = 0; r < sse_pkg::ROWS; r++) begin
			if (sse_pkg::ROW_W'(r) != asg_row_q && map_q[r] == {1'b0, asg_note_q}) begin
				in_use = 1'b1;
			end
		end
	end

	// Memory ports
	always_comb begin
		g_we    = 1'b0;
		g_waddr = sse_pkg::CELL_W'(int'(row_index) * sse_pkg::STEPS + int'(column_index));
		g_wdata = cell_velocity;
		g_raddr = sse_pkg::CELL_W'(int'(row_q) * sse_pkg::STEPS + int'(step_q));
		c_we    = 1'b0;
		c_waddr = note_q;
		c_wdata = 8'd0;
		c_raddr = cur_note[6:0];
		case (state_q)
			S_CLEAR: begin
				if (clr_grid_q && int'(sweep_q) < sse_pkg::CELLS) begin
					g_we    = 1'b1;
					g_waddr = sweep_q[sse_pkg::CELL_W-1:0];
					g_wdata = 7'd0;
				end
				if (int'(sweep_q) < sse_pkg::NOTES) begin
					c_we    = 1'b1;
					c_waddr = sweep_q[sse_pkg::NOTE_W-1:0];
				end
			end
			S_IDLE: begin
				g_we = accept && req_type == sse_pkg::REQ_GRID
					&& int'(row_index) < sse_pkg::ROWS && int'(column_index) < sse_pkg::STEPS;
			end
			S_EVAL: begin
				if (set_c && !act_c) begin
					c_we    = 1'b1;
					c_wdata = 8'd1;
				end else if (!set_c && act_c) begin
					c_we    = 1'b1;
					c_wdata = c_rdata - 8'd1;
				end
			end
			S_SCAN_RD: begin
				g_raddr = sse_pkg::CELL_W'(int'(row_q) * sse_pkg::STEPS + int'(scan_q));
			end
			S_ASG: begin
				c_raddr = old_note[6:0];
			end
			S_ASG_EV: begin
				if (act_c) begin
					c_we    = 1'b1;
					c_wdata = c_rdata - 8'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Message generation
	always_comb begin
		emit     = 1'b0;
		emit_msg = '{tm: t_q, status: sse_pkg::STAT_NOTE_OFF | {4'd0, chan_q},
			d1: note_q, d2: 7'd0};
		case (state_q)
			S_EVAL: begin
				if (set_c && act_c && drum_q) begin
					emit        = 1'b1;
					emit_msg.tm = t_off;
				end else if (set_c && !act_c) begin
					emit            = 1'b1;
					emit_msg.status = sse_pkg::STAT_NOTE_ON | {4'd0, chan_q};
					emit_msg.d2     = g_rdata;
				end else if (!set_c && act_c) begin
					emit = 1'b1;
				end
			end
			S_RETRIG: begin
				// the note-on sounds only if the note-off silenced it
				if (cnt_q == 8'd1) begin
					emit            = 1'b1;
					emit_msg.tm     = t_on;
					emit_msg.status = sse_pkg::STAT_NOTE_ON | {4'd0, chan_q};
					emit_msg.d2     = vel_q;
				end
			end
			S_SCAN_CK: begin
				if (g_rdata != 7'd0 && int'(scan_q) == sse_pkg::STEPS - 1) begin
					emit        = 1'b1;
					emit_msg.tm = t_off;
				end
			end
			S_ASG_EV: begin
				if (act_c) begin
					emit        = 1'b1;
					emit_msg.tm = 16'd0;
				end
			end
			S_PANIC: begin
				emit     = 1'b1;
				emit_msg = '{tm: 16'd0, status: sse_pkg::STAT_CTRL | {4'd0, pan_q[4:1]},
					d1: pan_q[0] ? sse_pkg::CC_ALL_OFF : sse_pkg::CC_SUSTAIN, d2: 7'd0};
			end
			default: begin
			end
		endcase
	end

	sse_ram #(.W(7), .D(sse_pkg::CELLS)) u_grid (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(g_raddr), .rdata(g_rdata)
	);

	sse_ram #(.W(8), .D(sse_pkg::NOTES)) u_count (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			sweep_q      <= '0;
			clr_grid_q   <= 1'b1;
			clr_after_q  <= 1'b0;
			step_q       <= sse_pkg::STEP_W'(sse_pkg::STEPS - 1);
			row_q        <= '0;
			scan_q       <= '0;
			pan_q        <= '0;
			chan_q       <= 4'd0;
			drum_q       <= 1'b0;
			pend_vld_q   <= 1'b0;
			event_strobe <= 1'b0;
			last_of_run  <= 1'b0;
			for (int r = 0; r < sse_pkg::ROWS; r++) begin
				map_q[r] <= sse_pkg::ROW_DISABLED;
			end
		end else begin
			event_strobe <= 1'b0;
			last_of_run  <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					sse_pkg::CFG_CHANNEL: chan_q <= cfg_data;
					sse_pkg::CFG_DRUM:    drum_q <= cfg_data[0];
					default: begin
					end
				endcase
			end

			// hold each beat until the next one is made so the final one can carry last_of_run
			if (emit) begin
				if (pend_vld_q) begin
					event_strobe <= 1'b1;
					event_time   <= pend_q.tm;
					status_byte  <= pend_q.status;
					data_one     <= pend_q.d1;
					data_two     <= pend_q.d2;
				end
				pend_q     <= emit_msg;
				pend_vld_q <= 1'b1;
			end

			case (state_q)
				S_CLEAR: begin
					if (int'(sweep_q) == sse_pkg::SWEEP_N - 1) begin
						sweep_q    <= '0;
						clr_grid_q <= 1'b0;
						state_q    <= S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (req_type)
							sse_pkg::REQ_TICK: begin
								step_q  <= (int'(step_q) == sse_pkg::STEPS - 1) ? '0
									: step_q + 1'b1;
								t_q     <= time_offset;
								row_q   <= '0;
								state_q <= S_ROW;
							end
							sse_pkg::REQ_ASSIGN: begin
								if (int'(row_index) < sse_pkg::ROWS) begin
									asg_row_q  <= sse_pkg::ROW_W'(row_index);
									asg_note_q <= row_note;
									state_q    <= S_ASG;
								end
							end
							sse_pkg::REQ_PANIC: begin
								pan_q       <= '0;
								clr_after_q <= 1'b1;
								step_q      <= sse_pkg::STEP_W'(sse_pkg::STEPS - 1);
								state_q     <= S_PANIC;
							end
							default: begin
							end
						endcase
					end
				end
				S_ROW: begin
					if (cur_note[7]) begin
						if (int'(row_q) == sse_pkg::ROWS - 1) begin
							state_q <= S_FINISH;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						note_q  <= cur_note[6:0];
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					cnt_q <= c_rdata;
					vel_q <= g_rdata;
					if (set_c && act_c && drum_q) begin
						state_q <= S_RETRIG;
					end else if (set_c && act_c && step_q == '0) begin
						scan_q  <= '0;
						state_q <= S_SCAN_RD;
					end else if (int'(row_q) == sse_pkg::ROWS - 1) begin
						state_q <= S_FINISH;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_ROW;
					end
				end
				S_RETRIG: begin
					if (int'(row_q) == sse_pkg::ROWS - 1) begin
						state_q <= S_FINISH;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_ROW;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CK;
				end
				S_SCAN_CK: begin
					if (g_rdata == 7'd0) begin
						if (int'(row_q) == sse_pkg::ROWS - 1) begin
							state_q <= S_FINISH;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= S_ROW;
						end
					end else if (int'(scan_q) == sse_pkg::STEPS - 1) begin
						state_q <= S_RETRIG;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_ASG: begin
					if (old_note == {1'b0, asg_note_q}) begin
						state_q <= S_FINISH;
					end else begin
						map_q[asg_row_q] <= in_use ? sse_pkg::ROW_DISABLED : {1'b0, asg_note_q};
						note_q           <= old_note[6:0];
						state_q          <= old_note[7] ? S_FINISH : S_ASG_EV;
					end
				end
				S_ASG_EV: begin
					state_q <= S_FINISH;
				end
				S_PANIC: begin
					if (int'(pan_q) == sse_pkg::PANIC_N - 1) begin
						state_q <= S_FINISH;
					end else begin
						pan_q <= pan_q + 1'b1;
					end
				end
				S_FINISH: begin
					// flush the held beat as the last of the run
					if (pend_vld_q) begin
						event_strobe <= 1'b1;
						last_of_run  <= 1'b1;
						event_time   <= pend_q.tm;
						status_byte  <= pend_q.status;
						data_one     <= pend_q.d1;
						data_two     <= pend_q.d2;
						pend_vld_q   <= 1'b0;
					end
					clr_after_q <= 1'b0;
					state_q     <= clr_after_q ? S_CLEAR : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

>>> rtl/core/sse_checker.sv
// Port-level checker for the step sequencer engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  req_type,
	input logic [15:0] time_offset,
	input logic [2:0]  row_index,
	input logic [2:0]  column_index,
	input logic [6:0]  cell_velocity,
	input logic [6:0]  row_note,
	input logic        cfg_we,
	input logic        cfg_index,
	input logic [3:0]  cfg_data,
	input logic        event_strobe,
	input logic [15:0] event_time,
	input logic [7:0]  status_byte,
	input logic [6:0]  data_one,
	input logic [6:0]  data_two,
	input logic        last_of_run
);
	`AST_NEXT(a_tick_busy, start && !busy && req_type == sse_pkg::REQ_TICK, busy)
	`AST_NEXT(a_panic_busy, start && !busy && req_type == sse_pkg::REQ_PANIC, busy)
	`AST_IMPL(a_last_strobe, last_of_run, event_strobe)
	`AST_IMPL(a_ctrl_zero, event_strobe && status_byte[7:4] == 4'hB, data_two == 7'd0)
	`AST_IMPL(a_off_zero, event_strobe && status_byte[7:4] == 4'h8, data_two == 7'd0)
endmodule

bind midi_step_sequencer_engine sse_checker u_sse_checker (.*);
